>>> rtl/core/c2s_pkg.sv
package c2s_pkg;

  // Field widths of the coordinate and angle words.
  localparam int COORD_WIDTH   = 16;
  localparam int ANGLE_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;

  // Fraction bits carried by scaled coordinates and by the horizontal length.
  localparam int H_FRAC = 32 - COORD_WIDTH;

  // Square root datapath: radicand word, root bits and partial remainder.
  localparam int SQ_IN_W = 2 * COORD_WIDTH;
  localparam int RT_W    = COORD_WIDTH + H_FRAC;
  localparam int REM_W   = RT_W + 2;

  // CORDIC vector word: a root-sized magnitude, the gain and a sign bit.
  localparam int CORDIC_W = RT_W + 3;

  // Internal angle word in which 2^31 stands for pi, with headroom for pi plus the table sum.
  localparam int ANG_INT_W = 34;
  localparam int ANG_SHIFT = 32 - ANGLE_WIDTH;
  localparam int ANG_RND_W = ANG_INT_W - ANG_SHIFT;
  localparam int EL_LIM    = 2 ** (ANGLE_WIDTH - 2);

  localparam int TABLE_LEN = 32;

  // Pipeline stage positions, counted from the input register.
  localparam int ST_SUM  = 2;
  localparam int ST_ROOT = ST_SUM + RT_W;
  localparam int ST_H    = ST_ROOT + 1;
  localparam int CD_LAT  = CORDIC_STAGES + 1;
  localparam int ST_EL   = ST_H + CD_LAT;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic        [COORD_WIDTH-1:0] radius_t;
  typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
  typedef logic signed [CORDIC_W-1:0]    cvec_t;
  typedef logic signed [ANG_INT_W-1:0]   iang_t;

  localparam iang_t PI_INT = iang_t'(64'd2147483648);

  // atan(2^-i) / pi * 2^31, rounded.
  localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

endpackage

>>> rtl/core/c2s_in_if.sv
interface c2s_in_if;
  import c2s_pkg::*;

  logic   valid;
  logic   ready;
  coord_t x_coord;
  coord_t y_coord;
  coord_t z_coord;

  modport source (output valid, output x_coord, output y_coord, output z_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, input z_coord, output ready);

endinterface

>>> rtl/core/c2s_out_if.sv
interface c2s_out_if;
  import c2s_pkg::*;

  logic    valid;
  logic    ready;
  radius_t radius;
  angle_t  azimuth;
  angle_t  elevation;

  modport source (output valid, output radius, output azimuth, output elevation, input ready);
  modport sink   (input valid, input radius, input azimuth, input elevation, output ready);

endinterface

>>> rtl/core/c2s_sqrt.sv
module c2s_sqrt (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [c2s_pkg::SQ_IN_W-1:0]   rad_i,
  output logic [c2s_pkg::RT_W-1:0]      root_o,
  output logic [c2s_pkg::REM_W-1:0]     rem_o
);
  import c2s_pkg::*;

  // Restoring square root of rad_i * 2^(2*H_FRAC), one root bit per stage.
  logic [REM_W-1:0]   rem_q  [RT_W];
  logic [RT_W-1:0]    root_q [RT_W];
  logic [SQ_IN_W-1:0] rad_q  [RT_W-1];

  for (genvar k = 0; k < RT_W; k++) begin : g_stage
    logic [REM_W-1:0]   rem_in;
    logic [RT_W-1:0]    root_in;
    logic [SQ_IN_W-1:0] rad_in;
    logic [REM_W+1:0]   rem_x;
    logic [REM_W+1:0]   trial;
    logic [REM_W+1:0]   diff;
    logic               take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    // Bring down the next pair of radicand bits and try the next root bit.
    assign rem_x = {rem_in, rad_in[SQ_IN_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign diff  = rem_x - trial;
    assign take  = (rem_x >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? diff[REM_W-1:0] : rem_x[REM_W-1:0];
        root_q[k] <= {root_in[RT_W-2:0], take};
      end
    end

    // The radicand shifts up by one pair per stage; the last stage needs none.
    if (k < RT_W - 1) begin : g_rad
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rad_q[k] <= {rad_in[SQ_IN_W-3:0], 2'b00};
        end
      end
    end
  end

  assign root_o = root_q[RT_W-1];
  assign rem_o  = rem_q[RT_W-1];

endmodule

>>> rtl/core/c2s_cordic.sv
module c2s_cordic (
  input  logic           clk_i,
  input  logic           en_i,
  input  c2s_pkg::cvec_t xv_i,
  input  c2s_pkg::cvec_t yv_i,
  output c2s_pkg::iang_t ang_o
);
  import c2s_pkg::*;

  // Entry 0 is the pre-rotation register; entry k+1 follows micro-rotation k.
  cvec_t x_q    [CORDIC_STAGES+1];
  cvec_t y_q    [CORDIC_STAGES+1];
  iang_t a_q    [CORDIC_STAGES+1];
  logic  zero_q [CORDIC_STAGES+1];

  // Fold the left half-plane onto the right one by negating and adding pi.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (xv_i == '0) && (yv_i == '0);
      if (xv_i < 0) begin
        x_q[0] <= -xv_i;
        y_q[0] <= -yv_i;
        a_q[0] <= PI_INT;
      end else begin
        x_q[0] <= xv_i;
        y_q[0] <= yv_i;
        a_q[0] <= '0;
      end
    end
  end

  // Vectoring micro-rotations, each with a fixed shift and table entry.
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
    localparam iang_t TAB = iang_t'(ATAN_TAB[k]);
    cvec_t xs;
    cvec_t ys;

    assign xs = x_q[k] >>> k;
    assign ys = y_q[k] >>> k;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[k+1] <= zero_q[k];
        if (y_q[k] >= 0) begin
          x_q[k+1] <= x_q[k] + ys;
          y_q[k+1] <= y_q[k] - xs;
          a_q[k+1] <= a_q[k] + TAB;
        end else begin
          x_q[k+1] <= x_q[k] - ys;
          y_q[k+1] <= y_q[k] + xs;
          a_q[k+1] <= a_q[k] - TAB;
        end
      end
    end
  end

  // A zero vector has angle zero by definition.
  assign ang_o = zero_q[CORDIC_STAGES] ? '0 : a_q[CORDIC_STAGES];

endmodule

>>> rtl/core/cartesian_to_spherical_top.sv
// Cartesian to spherical conversion of a 3-D position.
// The input channel coord_i carries a word of signed x, y and z coordinates;
// the output channel sph_o returns one word for each: the rounded radius,
// the azimuth atan2(z, x) and the elevation atan2(y, horizontal length),
// both angles as signed binary fractions of pi.
// Both channels move a word at a rising edge where valid and ready are high.
// The datapath is a 53-stage pipeline followed by an output register, taking
// one word per cycle while the receiver does not stall. Its depth comes from
// the two 32-stage square root pipelines (one root bit per stage), run side by
// side, and the 17-stage elevation CORDIC that the horizontal root feeds.
// When the receiver holds ready low, the result waits in the output register;
// the pipeline keeps moving until a word reaches its last stage, and only then
// does coord_i.ready fall. No word is lost or repeated.
// Reset (rst_ni low, asynchronous) empties the pipeline and the output
// register; no set-up is needed afterwards.
module cartesian_to_spherical_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  c2s_in_if.sink    coord_i,
  c2s_out_if.source sph_o
);
  import c2s_pkg::*;

  localparam int PIPE_DEPTH = ST_EL + 1;
  localparam int Y_DLY      = ST_H;
  localparam int AZ_DLY     = ST_EL - CD_LAT;
  localparam int R_DLY      = ST_EL - ST_ROOT;
  localparam int ANG_RND    = 2 ** (ANG_SHIFT - 1);
  localparam int R_RND      = 2 ** (H_FRAC - 1);

  localparam logic signed [ANG_RND_W-1:0] EL_HI = ANG_RND_W'(EL_LIM);
  localparam logic signed [ANG_RND_W-1:0] EL_LO = -EL_HI;

  // Scale a coordinate by 2^H_FRAC into the CORDIC word.
  function automatic cvec_t scale_coord(coord_t c);
    return cvec_t'(signed'({c, {H_FRAC{1'b0}}}));
  endfunction

  // Round an internal angle to the output scale, floor after adding a half.
  function automatic logic signed [ANG_RND_W-1:0] angle_round(iang_t a);
    iang_t biased;
    biased = a + iang_t'(ANG_RND);
    return signed'(biased[ANG_INT_W-1:ANG_SHIFT]);
  endfunction

  logic                  en;
  logic                  out_free;
  logic [PIPE_DEPTH-1:0] vld_q;

  coord_t             x_q, y_q, z_q;
  logic [SQ_IN_W-1:0] xx_q, yy_q, zz_q;
  logic [SQ_IN_W-1:0] hsq_q, ss_q;
  logic [RT_W-1:0]    h_q;

  logic signed [SQ_IN_W-1:0] xx_d, yy_d, zz_d;
  logic [RT_W-1:0]           h_root;
  logic [REM_W-1:0]          h_rem;
  logic [RT_W-1:0]           r_root;
  logic [RT_W:0]             r_sum;

  coord_t  y_dly_q  [Y_DLY];
  angle_t  az_dly_q [AZ_DLY];
  radius_t r_dly_q  [R_DLY];

  iang_t az_ang;
  iang_t el_ang;
  logic signed [ANG_RND_W-1:0] az_rnd;
  logic signed [ANG_RND_W-1:0] el_rnd;
  logic signed [ANG_RND_W-1:0] el_clamp;

  logic    out_valid_q;
  radius_t radius_q;
  angle_t  azimuth_q;
  angle_t  elevation_q;

  // The pipeline advances unless a result in its last stage has nowhere to go.
  assign out_free      = !out_valid_q || sph_o.ready;
  assign en            = out_free || !vld_q[PIPE_DEPTH-1];
  assign coord_i.ready = en;

  // Valid bits travel alongside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], coord_i.valid};
    end
  end

  // Input register, squares and the two sums of squares.
  assign xx_d = x_q * x_q;
  assign yy_d = y_q * y_q;
  assign zz_d = z_q * z_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q   <= coord_i.x_coord;
      y_q   <= coord_i.y_coord;
      z_q   <= coord_i.z_coord;
      xx_q  <= xx_d;
      yy_q  <= yy_d;
      zz_q  <= zz_d;
      hsq_q <= xx_q + zz_q;
      ss_q  <= xx_q + zz_q + yy_q;
    end
  end

  // Square roots of the horizontal and full squared lengths.
  c2s_sqrt u_sqrt_h (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (hsq_q),
    .root_o (h_root),
    .rem_o  (h_rem)
  );

  c2s_sqrt u_sqrt_r (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (ss_q),
    .root_o (r_root),
    .rem_o  ()
  );

  // The radius root carries H_FRAC fraction bits, so rounding is add half, drop.
  assign r_sum = {1'b0, r_root} + (RT_W + 1)'(R_RND);

  // Round the horizontal length up when the remainder exceeds the root.
  always_ff @(posedge clk_i) begin
    if (en) begin
      h_q <= h_root + RT_W'(h_rem > REM_W'(h_root));
    end
  end

  // Delay lines that line up y, the radius and the azimuth with the elevation.
  always_ff @(posedge clk_i) begin
    if (en) begin
      y_dly_q[0] <= y_q;
      for (int k = 1; k < Y_DLY; k++) begin
        y_dly_q[k] <= y_dly_q[k-1];
      end
      r_dly_q[0] <= r_sum[H_FRAC +: COORD_WIDTH];
      for (int k = 1; k < R_DLY; k++) begin
        r_dly_q[k] <= r_dly_q[k-1];
      end
      az_dly_q[0] <= az_rnd[ANGLE_WIDTH-1:0];
      for (int k = 1; k < AZ_DLY; k++) begin
        az_dly_q[k] <= az_dly_q[k-1];
      end
    end
  end

  // Azimuth in the x-z plane, started straight from the input register.
  c2s_cordic u_cordic_az (
    .clk_i (clk_i),
    .en_i  (en),
    .xv_i  (scale_coord(x_q)),
    .yv_i  (scale_coord(z_q)),
    .ang_o (az_ang)
  );

  assign az_rnd = angle_round(az_ang);

  // Elevation against the horizontal length.
  c2s_cordic u_cordic_el (
    .clk_i (clk_i),
    .en_i  (en),
    .xv_i  (cvec_t'(h_q)),
    .yv_i  (scale_coord(y_dly_q[Y_DLY-1])),
    .ang_o (el_ang)
  );

  // Round the elevation and keep it within plus or minus half pi.
  always_comb begin
    el_rnd   = angle_round(el_ang);
    el_clamp = el_rnd;
    if (el_rnd > EL_HI) begin
      el_clamp = EL_HI;
    end else if (el_rnd < EL_LO) begin
      el_clamp = EL_LO;
    end
  end

  // Output register holds a result until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= vld_q[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      radius_q    <= r_dly_q[R_DLY-1];
      azimuth_q   <= az_dly_q[AZ_DLY-1];
      elevation_q <= el_clamp[ANGLE_WIDTH-1:0];
    end
  end

  assign sph_o.valid     = out_valid_q;
  assign sph_o.radius    = radius_q;
  assign sph_o.azimuth   = azimuth_q;
  assign sph_o.elevation = elevation_q;

endmodule

>>> test/c2s_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the spherical converter, works out the spherical
// form of every accepted coordinate word and compares it with the words that
// leave the block, oldest first.
module c2s_checker (
  input  logic clk_i,
  input  logic rst_ni,
  c2s_in_if    coord_mon,
  c2s_out_if   sph_mon,
  output int   fail_count_o,
  output int   pending_o
);
  import c2s_pkg::*;

  // Iteration count of the angle search and the bits dropped from the internal angle.
  localparam int N_ITER   = CORDIC_STAGES;
  localparam int ANG_DROP = 32 - ANGLE_WIDTH;
  localparam int FRAC     = 32 - COORD_WIDTH;
  localparam longint EL_BOUND = longint'(1) <<< (ANGLE_WIDTH - 2);

  typedef struct packed {
    radius_t radius;
    angle_t  azimuth;
    angle_t  elevation;
  } sph_word_t;

  sph_word_t sph_q[$];

  // Rotation angle of step i: atan(2^-i) as a fraction of pi, 2^31 being pi.
  function automatic longint rot_angle(int i);
    case (i)
      0:  return 536870912;
      1:  return 316933406;
      2:  return 167458907;
      3:  return 85004756;
      4:  return 42667331;
      5:  return 21354465;
      6:  return 10679838;
      7:  return 5340245;
      8:  return 2670163;
      9:  return 1335087;
      10: return 667544;
      11: return 333772;
      12: return 166886;
      13: return 83443;
      14: return 41722;
      15: return 20861;
      16: return 10430;
      17: return 5215;
      18: return 2608;
      19: return 1304;
      20: return 652;
      21: return 326;
      22: return 163;
      23: return 81;
      24: return 41;
      25: return 20;
      26: return 10;
      27: return 5;
      28: return 3;
      29: return 1;
      30: return 1;
      default: return 0;
    endcase
  endfunction

  // Integer square root, rounded half up, one root bit per pass.
  function automatic longint unsigned root_rounded(longint unsigned v);
    longint unsigned rest;
    longint unsigned root;
    longint unsigned probe;
    rest  = v;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (rest >= root + probe) begin
        rest = rest - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    if (v > root * root + root) root = root + 1;
    return root;
  endfunction

  // Vectoring search for atan2(yv, xv); the left half-plane is folded over first.
  function automatic longint vector_angle(longint yv, longint xv);
    longint px;
    longint py;
    longint acc;
    longint sx;
    longint sy;
    int     i;
    if (xv == 0 && yv == 0) return 0;
    px  = xv;
    py  = yv;
    acc = 0;
    if (px < 0) begin
      px  = -px;
      py  = -py;
      acc = longint'(1) <<< 31;
    end
    for (i = 0; i < N_ITER; i++) begin
      sx = px >>> i;
      sy = py >>> i;
      if (py >= 0) begin
        px  = px + sy;
        py  = py - sx;
        acc = acc + rot_angle(i);
      end else begin
        px  = px - sy;
        py  = py + sx;
        acc = acc - rot_angle(i);
      end
    end
    return acc;
  endfunction

  // Narrows an internal angle to the output width, rounding half up.
  function automatic longint angle_narrow(longint a);
    if (ANG_DROP == 0) return a;
    return (a + (longint'(1) <<< (ANG_DROP - 1))) >>> ANG_DROP;
  endfunction

  // Spherical form of one coordinate word.
  function automatic sph_word_t to_spherical(coord_t xc, coord_t yc, coord_t zc);
    longint          sx;
    longint          sy;
    longint          sz;
    longint          az;
    longint          el;
    longint unsigned flat_sq;
    longint unsigned vert_sq;
    longint unsigned h_len;
    sph_word_t       w;
    sx      = xc;
    sy      = yc;
    sz      = zc;
    flat_sq = sx * sx + sz * sz;
    vert_sq = sy * sy;
    w.radius = radius_t'(root_rounded(flat_sq + vert_sq));
    h_len   = root_rounded(flat_sq << (2 * FRAC));
    az      = angle_narrow(vector_angle(sz <<< FRAC, sx <<< FRAC));
    el      = angle_narrow(vector_angle(sy <<< FRAC, longint'(h_len)));
    // The elevation can overshoot a quarter turn by a few steps; clamp it.
    if (el > EL_BOUND) el = EL_BOUND;
    if (el < -EL_BOUND) el = -EL_BOUND;
    w.azimuth   = angle_t'(az);
    w.elevation = angle_t'(el);
    return w;
  endfunction

  // Compare each result word with the oldest prediction, then record new inputs.
  always @(posedge clk_i or negedge rst_ni) begin
    sph_word_t want;
    int        errs;
    errs = 0;
    if (!rst_ni) begin
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (sph_mon.valid && sph_mon.ready) begin
        if (sph_q.size() == 0) begin
          $error("result word with no prediction waiting: radius %0d", sph_mon.radius);
          errs = errs + 1;
        end else begin
          want = sph_q.pop_front();
          if (sph_mon.radius !== want.radius) begin
            $error("radius: expected %0d, actual %0d", want.radius, sph_mon.radius);
            errs = errs + 1;
          end
          if (sph_mon.azimuth !== want.azimuth) begin
            $error("azimuth: expected %0d, actual %0d", want.azimuth, sph_mon.azimuth);
            errs = errs + 1;
          end
          if (sph_mon.elevation !== want.elevation) begin
            $error("elevation: expected %0d, actual %0d", want.elevation,
                   sph_mon.elevation);
            errs = errs + 1;
          end
        end
      end
      if (coord_mon.valid && coord_mon.ready) begin
        sph_q.push_back(to_spherical(coord_mon.x_coord, coord_mon.y_coord,
                                     coord_mon.z_coord));
      end
      fail_count_o <= fail_count_o + errs;
      pending_o    <= sph_q.size();
    end
  end

endmodule

>>> test/tb_cartesian_to_spherical_top.sv
`timescale 1ns / 100ps

// Drives coordinate words into the converter with random gaps and back-pressure,
// and gives the verdict from the checker's failure and pending counts.
module tb_cartesian_to_spherical_top;
  import c2s_pkg::*;

  localparam coord_t C_MIN = 16'sh8000;
  localparam coord_t C_MAX = 16'sh7FFF;
  localparam int DRAIN_CYCLES = 64;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   pending_count;
  int   in_idle_pct;
  int   out_idle_pct;

  c2s_in_if  coord_if ();
  c2s_out_if sph_if ();

  cartesian_to_spherical_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .coord_i (coord_if),
    .sph_o   (sph_if)
  );

  c2s_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .coord_mon    (coord_if),
    .sph_mon      (sph_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: ready drops at random at the current stall rate.
  always @(posedge clk_i) begin
    sph_if.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Offers one word, with random idle cycles first, and holds it until it is taken.
  task automatic send_word(coord_t xc, coord_t yc, coord_t zc);
    while ($urandom_range(99) < in_idle_pct) begin
      coord_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    coord_if.valid   <= 1'b1;
    coord_if.x_coord <= xc;
    coord_if.y_coord <= yc;
    coord_if.z_coord <= zc;
    do @(posedge clk_i); while (!coord_if.ready);
  endtask

  // Holds the sender off until every predicted word has come back.
  task automatic drain();
    coord_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  // Mostly full-range values, with small values, extremes and zeros mixed in.
  function automatic coord_t pick_coord();
    case ($urandom_range(9))
      6, 7: return coord_t'(int'($urandom_range(32)) - 16);
      8: begin
        case ($urandom_range(4))
          0: return C_MIN;
          1: return C_MAX;
          2: return coord_t'(-1);
          3: return coord_t'(1);
          default: return '0;
        endcase
      end
      9: return '0;
      default: return coord_t'($urandom());
    endcase
  endfunction

  task automatic send_random(int count);
    repeat (count) send_word(pick_coord(), pick_coord(), pick_coord());
  endtask

  // Stimulus and verdict.
  initial begin
    rst_ni           = 1'b0;
    in_idle_pct      = 19;
    out_idle_pct     = 64;
    coord_if.valid   = 1'b0;
    coord_if.x_coord = '0;
    coord_if.y_coord = '0;
    coord_if.z_coord = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero vector, axis extremes and both corners of the cube.
    send_word('0, '0, '0);
    send_word(C_MAX, '0, '0);
    send_word(C_MIN, '0, '0);
    send_word('0, C_MAX, '0);
    send_word('0, C_MIN, '0);
    send_word('0, '0, C_MAX);
    send_word('0, '0, C_MIN);
    send_word(C_MAX, C_MAX, C_MAX);
    send_word(C_MIN, C_MIN, C_MIN);
    // Azimuth close to a half turn, where rounding wraps it to minus pi.
    send_word(coord_t'(-1), '0, '0);
    send_word(C_MIN, '0, coord_t'(1));
    send_word(C_MIN, '0, coord_t'(-1));
    send_word(coord_t'(-20000), coord_t'(5), coord_t'(-1));
    // Nearly vertical vectors, where the elevation is clamped.
    send_word('0, coord_t'(1), '0);
    send_word('0, coord_t'(-1), '0);
    send_word(coord_t'(1), C_MAX, '0);
    send_word('0, C_MIN, coord_t'(-1));
    // Mixed signs and alternating bit patterns.
    send_word(coord_t'(1), coord_t'(1), coord_t'(1));
    send_word(coord_t'(-1), coord_t'(-1), coord_t'(-1));
    send_word(C_MAX, C_MIN, C_MAX);
    send_word(C_MIN, C_MAX, C_MIN);
    send_word(16'sh5555, 16'shAAAA, 16'sh5555);
    send_word(16'shAAAA, 16'sh5555, 16'shAAAA);
    send_word(coord_t'(12345), coord_t'(-23456), coord_t'(7890));

    // Sender idles little while the receiver stalls often.
    send_random(400);
    drain();

    // Roles swapped.
    in_idle_pct  = 64;
    out_idle_pct = 19;
    send_random(400);
    drain();

    // Full rate on both sides.
    in_idle_pct  = 0;
    out_idle_pct = 0;
    send_random(350);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/c2s_pkg.sv
rtl/core/c2s_in_if.sv
rtl/core/c2s_out_if.sv
rtl/core/c2s_sqrt.sv
rtl/core/c2s_cordic.sv
rtl/core/cartesian_to_spherical_top.sv
test/c2s_checker.sv
test/tb_cartesian_to_spherical_top.sv
